@@ design/ers_pkg.sv @@
// shared types, codes and constants for the euclidean rhythm sequencer
`default_nettype none

package ers_pkg;

    // field widths fixed by the transaction format
    localparam int OP_W       = 2;
    localparam int AMOUNT_W   = 5;
    localparam int POS_OUT_W  = 5;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 1;

    // default pattern capacity and reset values
    localparam int DEF_MAX_STEPS = 32;
    localparam int RESET_STEPS   = 16;
    localparam int RESET_FILLS   = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;
    localparam logic [OP_W-1:0] OP_ROTATE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [AMOUNT_W-1:0] rotate_amount;
    } t_in;

    typedef struct packed {
        logic                 gate;
        logic [POS_OUT_W-1:0] position;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic advance;
        logic restart;
        logic build_init;
        logic build_step;
        logic rot_init;
        logic rot_step;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic build_done;
        logic rot_done;
    } t_sts;

endpackage

`default_nettype wire

@@ design/euclidean_rhythm_sequencer.sv @@
// Euclidean rhythm sequencer: advance and restart give their result the cycle after acceptance.
// Rebuild clears the pattern and walks the shared rounding remainder, placing one hit or
// carrying the position one place per step, until all f hits are placed; rotate turns the
// pattern one place per cycle in the rotator for amount places. One transaction is in flight at
// a time; a new one is taken the cycle after the result is accepted. Synchronous active-low
// reset clears the pattern, sets the active length to 16, the position to 0, registers 4 and 16.
`default_nettype none

module euclidean_rhythm_sequencer
    import ers_pkg::*;
#(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in                  i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out                      o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing control
    ers_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // pattern state and arithmetic
    ers_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_rotate_amount (i_in.rotate_amount),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out           (o_out)
    );

endmodule

`default_nettype wire

@@ design/ers_ctrl.sv @@
// sequencing state machine: accepts a transaction, runs the loop, presents the result
`default_nettype none

module ers_ctrl
    import ers_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [OP_W-1:0] i_op,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output t_cmd                 o_cmd,
    input  wire t_sts            i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BUILD = 2'd1;
    localparam logic [1:0] S_ROT   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign w_accept    = i_in_valid && o_in_ready;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_ADVANCE: begin
                            o_cmd.advance = 1'b1;
                            n_state       = S_DONE;
                        end
                        OP_RESTART: begin
                            o_cmd.restart = 1'b1;
                            n_state       = S_DONE;
                        end
                        OP_REBUILD: begin
                            o_cmd.build_init = 1'b1;
                            n_state          = S_BUILD;
                        end
                        default: begin
                            o_cmd.rot_init = 1'b1;
                            n_state        = S_ROT;
                        end
                    endcase
                end
            end
            S_BUILD: begin
                if (i_sts.build_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.build_step = 1'b1;
                end
            end
            S_ROT: begin
                if (i_sts.rot_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rot_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // loop steps only happen while their loop is unfinished
    a_build_step_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.build_step |-> (r_state == S_BUILD) && !i_sts.build_done)
        else $error("build step issued outside an unfinished rebuild");

    a_rot_step_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rot_step |-> (r_state == S_ROT) && !i_sts.rot_done)
        else $error("rotate step issued outside an unfinished rotate");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before being taken");

endmodule

`default_nettype wire

@@ design/ers_datapath.sv @@
// pattern, position and configuration registers with the rebuild and rotate units
`default_nettype none

module ers_datapath
    import ers_pkg::*;
#(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [AMOUNT_W-1:0]  i_rotate_amount,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output t_out                      o_out
);

    // pattern span also covers the reset length
    localparam int SpanW = (MAX_STEPS > RESET_STEPS) ? MAX_STEPS : RESET_STEPS;
    localparam int PW    = $clog2(SpanW);
    localparam int AW    = $clog2(SpanW + 1);
    localparam int CW    = CFG_W + 1;
    localparam int RW    = $clog2(4 * SpanW) + 1;

    logic [CFG_W-1:0]    r_fill_count;
    logic [CFG_W-1:0]    r_step_count;
    logic [SpanW-1:0]    r_pattern;
    logic [SpanW-1:0]    n_pattern;
    logic [AW-1:0]       r_active;
    logic [PW-1:0]       r_pos;
    logic [AW-1:0]       r_fills;
    logic [AW-1:0]       r_idx;
    logic [PW-1:0]       r_where;
    logic [RW-1:0]       r_rem;
    logic [AMOUNT_W-1:0] r_rot_cnt;

    logic [CW-1:0]       w_steps_ext;
    logic [CW-1:0]       w_len;
    logic [CW-1:0]       w_fills_ext;
    logic [CW-1:0]       w_fills;
    logic [RW-1:0]       w_two_f;
    logic [RW-1:0]       w_two_n;
    logic                w_carry;
    logic [SpanW-1:0]    w_marked;
    logic [SpanW-1:0]    w_rotated;

    // clamp step and fill counts for a rebuild
    always_comb begin
        w_steps_ext = CW'(r_step_count);
        w_fills_ext = CW'(r_fill_count);
        if (w_steps_ext == '0) begin
            w_len = CW'(1);
        end else if (w_steps_ext > CW'(MAX_STEPS)) begin
            w_len = CW'(MAX_STEPS);
        end else begin
            w_len = w_steps_ext;
        end
        w_fills = (w_fills_ext > w_len) ? w_len : w_fills_ext;
    end

    // rounding remainder: compare against 2f, add 2n per hit
    assign w_two_f = RW'(r_fills) << 1;
    assign w_two_n = RW'(r_active) << 1;
    assign w_carry = (r_rem >= w_two_f);

    // pattern with the current hit position set
    always_comb begin
        for (int k = 0; k < SpanW; k++) begin
            w_marked[k] = r_pattern[k] || (r_where == PW'(k));
        end
    end

    // one-place right rotation inside the active length
    always_comb begin
        w_rotated[0] = r_pattern[PW'(r_active - AW'(1))];
        for (int k = 1; k < SpanW; k++) begin
            w_rotated[k] = (AW'(k) < r_active) ? r_pattern[k-1] : r_pattern[k];
        end
    end

    always_comb begin
        n_pattern = r_pattern;
        if (i_cmd.build_init) begin
            n_pattern = '0;
        end else if (i_cmd.build_step && !w_carry) begin
            n_pattern = w_marked;
        end else if (i_cmd.rot_step) begin
            n_pattern = w_rotated;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count <= CFG_W'(RESET_FILLS);
            r_step_count <= CFG_W'(RESET_STEPS);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FILL_COUNT) begin
                r_fill_count <= i_cfg_data;
            end
            if (i_cfg_index == CFG_STEP_COUNT) begin
                r_step_count <= i_cfg_data;
            end
        end
    end

    // architectural state: pattern, active length, play position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_active  <= AW'(RESET_STEPS);
            r_pos     <= '0;
        end else begin
            r_pattern <= n_pattern;
            if (i_cmd.build_init) begin
                r_active <= AW'(w_len);
            end
            if (i_cmd.advance) begin
                if ((AW'(r_pos) + AW'(1)) < r_active) begin
                    r_pos <= r_pos + PW'(1);
                end else begin
                    r_pos <= '0;
                end
            end else if (i_cmd.restart) begin
                r_pos <= '0;
            end
        end
    end

    // rebuild walk: one hit or one position carry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fills <= '0;
            r_idx   <= '0;
        end else if (i_cmd.build_init) begin
            r_fills <= AW'(w_fills);
            r_idx   <= '0;
        end else if (i_cmd.build_step && !w_carry) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_where <= '0;
            r_rem   <= RW'(w_fills);
        end else if (i_cmd.build_step) begin
            if (w_carry) begin
                r_rem   <= r_rem - w_two_f;
                r_where <= r_where + PW'(1);
            end else begin
                r_rem <= r_rem + w_two_n;
            end
        end
    end

    // rotate counter: one place per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_cnt <= '0;
        end else if (i_cmd.rot_init) begin
            r_rot_cnt <= i_rotate_amount;
        end else if (i_cmd.rot_step) begin
            r_rot_cnt <= r_rot_cnt - AMOUNT_W'(1);
        end
    end

    assign o_sts.build_done = (r_idx == r_fills);
    assign o_sts.rot_done   = (r_rot_cnt == '0);

    assign o_out.gate     = r_pattern[r_pos];
    assign o_out.position = POS_OUT_W'(r_pos);

    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_fills)
        else $error("hit index ran past the fill count");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.build_step && !w_carry) |-> (AW'(r_where) < r_active))
        else $error("hit placed outside the active length");

    a_cleared_on_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.build_init |=> (r_pattern == '0))
        else $error("pattern not cleared at rebuild start");

    a_rot_keeps_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rot_step |=> ($countones(r_pattern) == $countones($past(r_pattern))))
        else $error("rotation changed the number of hits");

endmodule

`default_nettype wire

@@ tb/euclidean_rhythm_sequencer_tb.sv @@
// self-checking testbench for the euclidean rhythm sequencer
`timescale 1ns / 100ps

module euclidean_rhythm_sequencer_tb
    import ers_pkg::*;
;

    localparam int NSTEPS       = DEF_MAX_STEPS;
    localparam int HOLD_LEN     = 300;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASES       = 12;
    localparam int DRAIN_CYCLES = 80;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FILL_COUNT;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out;

    euclidean_rhythm_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // sequencer state as predicted
    logic [NSTEPS-1:0] hit_bits;
    int                hit_len;
    int                play_pos;
    logic [CFG_W-1:0]  fill_reg;
    logic [CFG_W-1:0]  step_reg;

    t_out pending_beats[$];
    bit   idle_en   = 1'b1;
    bit   hold_req  = 1'b0;
    int   hold_left = 0;
    int   error_count;
    int   items_sent;
    int   beats_checked;
    int   rebuilds_sent;
    int   rotates_sent;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("timeout with %0d results still pending", pending_beats.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // spread the hits evenly over the latched length
    function automatic void build_pattern();
        int n;
        int f;
        int where;
        n = step_reg;
        if (n == 0) n = 1;
        if (n > NSTEPS) n = NSTEPS;
        f = fill_reg;
        if (f > n) f = n;
        hit_bits = '0;
        for (int i = 0; i < f; i++) begin
            where = (2 * i * n + f) / (2 * f);
            if (where < n) hit_bits[where] = 1'b1;
        end
        hit_len = n;
    endfunction

    // rotate right within the active length, upper bits untouched
    function automatic void rotate_pattern(input int amount);
        logic [NSTEPS-1:0] moved;
        logic [NSTEPS-1:0] mask;
        int amt;
        amt = amount % hit_len;
        if (amt != 0) begin
            moved = '0;
            for (int k = 0; k < hit_len; k++) begin
                if (hit_bits[k]) moved[(k + amt) % hit_len] = 1'b1;
            end
            mask = (hit_len >= NSTEPS) ? '1 : ((NSTEPS'(1) << hit_len) - 1);
            hit_bits = (hit_bits & ~mask) | moved;
        end
    endfunction

    // apply one operation to the predicted state and return the beat it gives
    function automatic t_out sequence_step(input t_in item);
        t_out beat;
        case (item.op)
            OP_ADVANCE: begin
                if (play_pos < hit_len - 1) play_pos++;
                else play_pos = 0;
            end
            OP_RESTART: play_pos = 0;
            OP_REBUILD: build_pattern();
            default:    rotate_pattern(int'(item.rotate_amount));
        endcase
        beat.gate     = hit_bits[play_pos];
        beat.position = play_pos[POS_OUT_W-1:0];
        return beat;
    endfunction

    // offer one transaction and log its expected beat when taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount);
        t_in item;
        int  gap;
        item.op            = op;
        item.rotate_amount = amount;
        gap = (idle_en && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_beats.push_back(sequence_step(item));
        items_sent++;
        if (op == OP_REBUILD) rebuilds_sent++;
        if (op == OP_ROTATE) rotates_sent++;
    endtask

    // stop offering and wait for every outstanding beat
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    // write both registers, only while the block is idle
    task automatic cfg_set(input logic [CFG_W-1:0] fills, input logic [CFG_W-1:0] steps);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FILL_COUNT;
        i_cfg_data  <= fills;
        @(posedge i_clk);
        fill_reg = fills;
        i_cfg_index <= CFG_STEP_COUNT;
        i_cfg_data  <= steps;
        @(posedge i_clk);
        step_reg = steps;
        i_cfg_we <= 1'b0;
    endtask

    // result checker and receiver ready
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                beats_checked++;
                if (pending_beats.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result gate %0b position %0d",
                             $time, o_out.gate, o_out.position);
                end else begin
                    want = pending_beats.pop_front();
                    if (o_out.gate !== want.gate) begin
                        error_count++;
                        $display("%0t: gate expected %0b actual %0b",
                                 $time, want.gate, o_out.gate);
                    end
                    if (o_out.position !== want.position) begin
                        error_count++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, o_out.position);
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 99) < 10) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // empty pattern straight after reset
    task automatic test_reset_state();
        send_item(OP_ADVANCE, '0);
        send_item(OP_ROTATE, 5'd31);
        send_item(OP_RESTART, 5'd31);
        drain();
    endtask

    // register extremes, rotate amounts of zero, a full turn and 31
    task automatic test_extremes();
        send_item(OP_REBUILD, '0);
        send_item(OP_ROTATE, 5'd0);
        send_item(OP_ROTATE, 5'd16);
        send_item(OP_ROTATE, 5'd31);
        send_item(OP_ADVANCE, '0);
        drain();
        cfg_set(6'd0, 6'd16);
        send_item(OP_REBUILD, '0);
        send_item(OP_ADVANCE, '0);
        drain();
        cfg_set(6'd32, 6'd32);
        send_item(OP_REBUILD, '0);
        send_item(OP_ROTATE, 5'd31);
        drain();
        // zero length taken as one, fills beyond length saturate
        cfg_set(6'd63, 6'd0);
        send_item(OP_REBUILD, '0);
        send_item(OP_ROTATE, 5'd5);
        drain();
        cfg_set(6'd5, 6'd63);
        send_item(OP_REBUILD, '0);
        send_item(OP_ROTATE, 5'd7);
        drain();
    endtask

    // position left beyond a shorter pattern until the next advance
    task automatic test_short_rebuild();
        cfg_set(6'd3, 6'd8);
        send_item(OP_REBUILD, '0);
        repeat (7) send_item(OP_ADVANCE, '0);
        drain();
        cfg_set(6'd2, 6'd3);
        send_item(OP_REBUILD, '0);
        send_item(OP_ROTATE, 5'd1);
        send_item(OP_ADVANCE, '0);
        drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (12) send_item(OP_W'($urandom_range(0, 3)), AMOUNT_W'($urandom));
        drain();
    endtask

    // one random operation, advances most often so positions travel far
    task automatic send_random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) send_item(OP_ADVANCE, AMOUNT_W'($urandom));
        else if (pick < 55) send_item(OP_RESTART, AMOUNT_W'($urandom));
        else if (pick < 72) send_item(OP_REBUILD, AMOUNT_W'($urandom));
        else send_item(OP_ROTATE, AMOUNT_W'($urandom));
    endtask

    // random phases over several register settings
    task automatic test_random_phases();
        logic [CFG_W-1:0] fills;
        logic [CFG_W-1:0] steps;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin fills = 6'd32; steps = 6'd32; end
                1: begin fills = 6'd0;  steps = 6'd1;  end
                2: begin fills = 6'd1;  steps = 6'd32; end
                3: begin fills = 6'd32; steps = 6'd1;  end
                default: begin
                    if ($urandom_range(0, 99) < 20) begin
                        fills = CFG_W'($urandom_range(0, 63));
                        steps = CFG_W'($urandom_range(0, 63));
                    end else begin
                        fills = CFG_W'($urandom_range(0, 32));
                        steps = CFG_W'($urandom_range(1, 32));
                    end
                end
            endcase
            cfg_set(fills, steps);
            idle_en = (p != 5);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random_op();
                // sender pause until the pipe is empty, mid phase
                if (p == 7 && k == PHASE_ITEMS / 2) drain();
            end
            drain();
        end
        idle_en = 1'b1;
    endtask

    // test sequence
    initial begin
        error_count   = 0;
        items_sent    = 0;
        beats_checked = 0;
        rebuilds_sent = 0;
        rotates_sent  = 0;
        hit_bits = '0;
        hit_len  = RESET_STEPS;
        play_pos = 0;
        fill_reg = CFG_W'(RESET_FILLS);
        step_reg = CFG_W'(RESET_STEPS);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_extremes();
        test_short_rebuild();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d transactions sent (%0d rebuilds, %0d rotates), %0d results checked",
                 items_sent, rebuilds_sent, rotates_sent, beats_checked);
        $display("register extremes, short rebuilds, long receiver hold and idle gaps covered");
        if (error_count == 0 && pending_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d results missing", error_count, pending_beats.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ euclidean_rhythm_sequencer.f @@
design/ers_pkg.sv
design/ers_ctrl.sv
design/ers_datapath.sv
design/euclidean_rhythm_sequencer.sv
tb/euclidean_rhythm_sequencer_tb.sv
